// ===== rtl/core/triangle_primitive_setup_defines.svh =====
// Assertion macros for the triangle primitive setup block.
// Included by the top level; expects a clock named clk and reset rst_n.
`ifndef TRIANGLE_PRIMITIVE_SETUP_DEFINES_SVH
`define TRIANGLE_PRIMITIVE_SETUP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/trs_pkg.sv =====
// Shared constants and register index codes for the triangle setup block.
// No dependencies; imported by every module of the block.
package trs_pkg;

  localparam int NUM_AXES      = 3;
  localparam int NUM_VERTS     = 3;
  localparam int INV_WIDTH     = 32;
  localparam int CENT_WIDTH    = 16;
  localparam int CENT_SHIFT    = 24;
  localparam int CFG_IDX_WIDTH = 3;
  // Normal components wrap at a 64-bit word before masking to port width
  localparam int NORMAL_WRAP_BITS = 64;

  localparam logic [CENT_WIDTH-1:0] CENT_MAX = {CENT_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SCENE_MIN_X  = 3'd0,
    REG_SCENE_MIN_Y  = 3'd1,
    REG_SCENE_MIN_Z  = 3'd2,
    REG_INV_EXTENT_X = 3'd3,
    REG_INV_EXTENT_Y = 3'd4,
    REG_INV_EXTENT_Z = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/core/triangle_primitive_setup.sv =====
// Triangle primitive setup: centroid, bounding box and face normal per triangle.
// Depends on trs_pkg, trs_cfg, trs_setup, trs_finish and the assertion macro header.
//
//   Port group | Direction | Handshake        | Moves
//   in_        | input     | valid / ready    | one triangle, nine vertex coordinates
//   out_       | output    | valid / ready    | centroid, box min/max, normal per triangle
//   cfg_       | input     | write enable     | scene minimum and inverse extent registers
//
// One triangle per cycle sustained while out_ready stays high; out_valid is registered through
// the input register, the divide-by-3 stage and the scaling and cross product stage.
// Each register stage keeps its own valid, so in_ready stays high while any stage is free;
// a stall on out_ready backs up one stage at a time.
// rst_n is synchronous; it clears the stage valids and the configuration registers.
`include "triangle_primitive_setup_defines.svh"

module triangle_primitive_setup import trs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // configuration
  input  logic                                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]                  cfg_index,
  input  logic [((COORD_WIDTH > INV_WIDTH) ? COORD_WIDTH : INV_WIDTH)-1:0] cfg_data,
  // triangle input
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [COORD_WIDTH-1:0]             in_vert0_x,
  input  logic signed [COORD_WIDTH-1:0]             in_vert0_y,
  input  logic signed [COORD_WIDTH-1:0]             in_vert0_z,
  input  logic signed [COORD_WIDTH-1:0]             in_vert1_x,
  input  logic signed [COORD_WIDTH-1:0]             in_vert1_y,
  input  logic signed [COORD_WIDTH-1:0]             in_vert1_z,
  input  logic signed [COORD_WIDTH-1:0]             in_vert2_x,
  input  logic signed [COORD_WIDTH-1:0]             in_vert2_y,
  input  logic signed [COORD_WIDTH-1:0]             in_vert2_z,
  // result output
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [CENT_WIDTH-1:0]                     out_centroid_x,
  output logic [CENT_WIDTH-1:0]                     out_centroid_y,
  output logic [CENT_WIDTH-1:0]                     out_centroid_z,
  output logic signed [COORD_WIDTH-1:0]             out_box_min_x,
  output logic signed [COORD_WIDTH-1:0]             out_box_min_y,
  output logic signed [COORD_WIDTH-1:0]             out_box_min_z,
  output logic signed [COORD_WIDTH-1:0]             out_box_max_x,
  output logic signed [COORD_WIDTH-1:0]             out_box_max_y,
  output logic signed [COORD_WIDTH-1:0]             out_box_max_z,
  output logic signed [2*COORD_WIDTH+1:0]           out_normal_x,
  output logic signed [2*COORD_WIDTH+1:0]           out_normal_y,
  output logic signed [2*COORD_WIDTH+1:0]           out_normal_z
);

  localparam int W          = COORD_WIDTH;
  localparam int CFG_DATA_W = (W > INV_WIDTH) ? W : INV_WIDTH;

  logic                 s0_valid_r;
  logic [W-1:0]         s0_vert_r   [NUM_VERTS][NUM_AXES];
  logic                 in_fire;
  logic                 s1_in_ready;
  logic                 s1_valid;
  logic                 fin_in_ready;
  logic [W-1:0]         scene_min   [NUM_AXES];
  logic [INV_WIDTH-1:0] inv_extent  [NUM_AXES];
  logic [W-1:0]         s1_quot     [NUM_AXES];
  logic [W:0]           s1_edge1    [NUM_AXES];
  logic [W:0]           s1_edge2    [NUM_AXES];
  logic [W-1:0]         s1_box_lo   [NUM_AXES];
  logic [W-1:0]         s1_box_hi   [NUM_AXES];
  logic [CENT_WIDTH-1:0] fin_centroid [NUM_AXES];
  logic [W-1:0]         fin_box_min [NUM_AXES];
  logic [W-1:0]         fin_box_max [NUM_AXES];
  logic [2*W+1:0]       fin_normal  [NUM_AXES];
  logic                 box_ordered;

  trs_cfg #(
    .COORD_WIDTH (W),
    .CFG_DATA_W  (CFG_DATA_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .scene_min  (scene_min),
    .inv_extent (inv_extent)
  );

  // Input register: take a transaction whenever this stage is empty or moving on
  assign in_ready = !s0_valid_r || s1_in_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_vert_r[0][0] <= in_vert0_x;
      s0_vert_r[0][1] <= in_vert0_y;
      s0_vert_r[0][2] <= in_vert0_z;
      s0_vert_r[1][0] <= in_vert1_x;
      s0_vert_r[1][1] <= in_vert1_y;
      s0_vert_r[1][2] <= in_vert1_z;
      s0_vert_r[2][0] <= in_vert2_x;
      s0_vert_r[2][1] <= in_vert2_y;
      s0_vert_r[2][2] <= in_vert2_z;
    end
  end

  trs_setup #(
    .COORD_WIDTH (W)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_ready  (s1_in_ready),
    .vert      (s0_vert_r),
    .out_valid (s1_valid),
    .out_ready (fin_in_ready),
    .quot      (s1_quot),
    .edge1     (s1_edge1),
    .edge2     (s1_edge2),
    .box_lo    (s1_box_lo),
    .box_hi    (s1_box_hi)
  );

  trs_finish #(
    .COORD_WIDTH (W)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid),
    .in_ready   (fin_in_ready),
    .quot       (s1_quot),
    .edge1      (s1_edge1),
    .edge2      (s1_edge2),
    .box_lo     (s1_box_lo),
    .box_hi     (s1_box_hi),
    .scene_min  (scene_min),
    .inv_extent (inv_extent),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .centroid   (fin_centroid),
    .box_min    (fin_box_min),
    .box_max    (fin_box_max),
    .normal     (fin_normal)
  );

  // Spread the result arrays onto the named ports
  assign out_centroid_x = fin_centroid[0];
  assign out_centroid_y = fin_centroid[1];
  assign out_centroid_z = fin_centroid[2];
  assign out_box_min_x  = fin_box_min[0];
  assign out_box_min_y  = fin_box_min[1];
  assign out_box_min_z  = fin_box_min[2];
  assign out_box_max_x  = fin_box_max[0];
  assign out_box_max_y  = fin_box_max[1];
  assign out_box_max_z  = fin_box_max[2];
  assign out_normal_x   = fin_normal[0];
  assign out_normal_y   = fin_normal[1];
  assign out_normal_z   = fin_normal[2];

  // Box ordering per axis, folded for the check below
  assign box_ordered = ($signed(out_box_min_x) <= $signed(out_box_max_x)) &&
                       ($signed(out_box_min_y) <= $signed(out_box_max_y)) &&
                       ($signed(out_box_min_z) <= $signed(out_box_max_z));

  // Input only backs up once every stage down to the output is full and stalled
  `TPS_ASSERT_NOW(a_stall_from_output, !in_ready, out_valid && !out_ready, "early in stall")
  // A result only appears after the middle stage held one
  `TPS_ASSERT_NEXT(a_no_spurious_result, !out_valid && !s1_valid, !out_valid, "spurious result")
  // Box ordering per axis
  `TPS_ASSERT_NOW(a_box_order, out_valid, box_ordered, "box min above box max")

endmodule

// ===== rtl/core/trs_cfg.sv =====
// Configuration register file: scene minimum and inverse extent per axis.
// Depends on trs_pkg for register index codes and widths.
module trs_cfg import trs_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int CFG_DATA_W  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic [COORD_WIDTH-1:0]   scene_min [NUM_AXES],
  output logic [INV_WIDTH-1:0]     inv_extent [NUM_AXES]
);

  logic [COORD_WIDTH-1:0] scene_min_r   [NUM_AXES];
  logic [COORD_WIDTH-1:0] scene_min_nxt [NUM_AXES];
  logic [INV_WIDTH-1:0]   inv_extent_r   [NUM_AXES];
  logic [INV_WIDTH-1:0]   inv_extent_nxt [NUM_AXES];

  // Decode the write; unknown indexes are dropped
  always_comb begin
    scene_min_nxt  = scene_min_r;
    inv_extent_nxt = inv_extent_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCENE_MIN_X:  scene_min_nxt[0]  = cfg_data[COORD_WIDTH-1:0];
        REG_SCENE_MIN_Y:  scene_min_nxt[1]  = cfg_data[COORD_WIDTH-1:0];
        REG_SCENE_MIN_Z:  scene_min_nxt[2]  = cfg_data[COORD_WIDTH-1:0];
        REG_INV_EXTENT_X: inv_extent_nxt[0] = cfg_data[INV_WIDTH-1:0];
        REG_INV_EXTENT_Y: inv_extent_nxt[1] = cfg_data[INV_WIDTH-1:0];
        REG_INV_EXTENT_Z: inv_extent_nxt[2] = cfg_data[INV_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        scene_min_r[a]  <= '0;
        inv_extent_r[a] <= '0;
      end
    end else begin
      scene_min_r  <= scene_min_nxt;
      inv_extent_r <= inv_extent_nxt;
    end
  end

  assign scene_min  = scene_min_r;
  assign inv_extent = inv_extent_r;

endmodule

// ===== rtl/core/trs_setup.sv =====
// First compute stage: vertex sum floor-divided by 3, edges and bounding box.
// Depends on trs_pkg; feeds trs_finish through its own pipeline register.
module trs_setup import trs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] vert [NUM_VERTS][NUM_AXES],
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] quot   [NUM_AXES],
  output logic [COORD_WIDTH:0]   edge1  [NUM_AXES],
  output logic [COORD_WIDTH:0]   edge2  [NUM_AXES],
  output logic [COORD_WIDTH-1:0] box_lo [NUM_AXES],
  output logic [COORD_WIDTH-1:0] box_hi [NUM_AXES]
);

  localparam int W         = COORD_WIDTH;
  localparam int SUM_W     = W + 2;
  localparam int DIV_SHIFT = W + 4;
  localparam int MUL_W     = W + 3;
  localparam int PROD_W    = SUM_W + MUL_W;

  // Reciprocal of 3 scaled by 2^DIV_SHIFT, rounded up: exact for SUM_W-bit dividends
  localparam logic [DIV_SHIFT:0] DIV_POW  = {1'b1, {DIV_SHIFT{1'b0}}};
  localparam logic [MUL_W-1:0]   DIV_MUL  = MUL_W'(DIV_POW / 3 + 1);
  // Bias that makes the smallest possible sum zero
  localparam logic [SUM_W-1:0]   DIV_BIAS = SUM_W'(3) << (W - 1);

  logic                   valid_r;
  logic                   load;
  logic [SUM_W-1:0]       sum        [NUM_AXES];
  logic [SUM_W-1:0]       biased     [NUM_AXES];
  logic [PROD_W-1:0]      recip_prod [NUM_AXES];
  logic [W-1:0]           quot_u     [NUM_AXES];
  logic [W-1:0]           quot_nxt   [NUM_AXES];
  logic [W:0]             edge1_nxt  [NUM_AXES];
  logic [W:0]             edge2_nxt  [NUM_AXES];
  logic [W-1:0]           lo_nxt     [NUM_AXES];
  logic [W-1:0]           hi_nxt     [NUM_AXES];
  logic [W-1:0]           quot_r     [NUM_AXES];
  logic [W:0]             edge1_r    [NUM_AXES];
  logic [W:0]             edge2_r    [NUM_AXES];
  logic [W-1:0]           box_lo_r   [NUM_AXES];
  logic [W-1:0]           box_hi_r   [NUM_AXES];

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Per-axis arithmetic, the axes are independent
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum[a] = {{2{vert[0][a][W-1]}}, vert[0][a]}
             + {{2{vert[1][a][W-1]}}, vert[1][a]}
             + {{2{vert[2][a][W-1]}}, vert[2][a]};
      // Floor division: divide the biased, non-negative sum, then remove the bias
      biased[a]     = sum[a] + DIV_BIAS;
      recip_prod[a] = PROD_W'(biased[a]) * PROD_W'(DIV_MUL);
      quot_u[a]     = recip_prod[a][DIV_SHIFT+W-1:DIV_SHIFT];
      quot_nxt[a]   = {~quot_u[a][W-1], quot_u[a][W-2:0]};

      edge1_nxt[a] = {vert[1][a][W-1], vert[1][a]} - {vert[0][a][W-1], vert[0][a]};
      edge2_nxt[a] = {vert[2][a][W-1], vert[2][a]} - {vert[0][a][W-1], vert[0][a]};

      lo_nxt[a] = vert[0][a];
      hi_nxt[a] = vert[0][a];
      for (int k = 1; k < NUM_VERTS; k++) begin
        if ($signed(vert[k][a]) < $signed(lo_nxt[a])) lo_nxt[a] = vert[k][a];
        if ($signed(vert[k][a]) > $signed(hi_nxt[a])) hi_nxt[a] = vert[k][a];
      end
    end
  end

  // Stage valid: fill on accept, drain when downstream takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      quot_r   <= quot_nxt;
      edge1_r  <= edge1_nxt;
      edge2_r  <= edge2_nxt;
      box_lo_r <= lo_nxt;
      box_hi_r <= hi_nxt;
    end
  end

  assign out_valid = valid_r;
  assign quot      = quot_r;
  assign edge1     = edge1_r;
  assign edge2     = edge2_r;
  assign box_lo    = box_lo_r;
  assign box_hi    = box_hi_r;

endmodule

// ===== rtl/core/trs_finish.sv =====
// Second compute stage: centroid scaling with saturation and edge cross product.
// Depends on trs_pkg; drives the result register of the block.
module trs_finish import trs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_WIDTH-1:0]     quot       [NUM_AXES],
  input  logic [COORD_WIDTH:0]       edge1      [NUM_AXES],
  input  logic [COORD_WIDTH:0]       edge2      [NUM_AXES],
  input  logic [COORD_WIDTH-1:0]     box_lo     [NUM_AXES],
  input  logic [COORD_WIDTH-1:0]     box_hi     [NUM_AXES],
  input  logic [COORD_WIDTH-1:0]     scene_min  [NUM_AXES],
  input  logic [INV_WIDTH-1:0]       inv_extent [NUM_AXES],
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CENT_WIDTH-1:0]      centroid   [NUM_AXES],
  output logic [COORD_WIDTH-1:0]     box_min    [NUM_AXES],
  output logic [COORD_WIDTH-1:0]     box_max    [NUM_AXES],
  output logic [2*COORD_WIDTH+1:0]   normal     [NUM_AXES]
);

  localparam int W      = COORD_WIDTH;
  localparam int NB     = 2 * W + 2;
  localparam int PROD_W = W + INV_WIDTH + 1;

  logic                     valid_r;
  logic                     load;
  logic [W:0]               diff      [NUM_AXES];
  logic                     diff_pos  [NUM_AXES];
  logic [PROD_W-1:0]        scale     [NUM_AXES];
  logic                     scale_sat [NUM_AXES];
  logic [CENT_WIDTH-1:0]    cent_nxt  [NUM_AXES];
  logic signed [W:0]        e1        [NUM_AXES];
  logic signed [W:0]        e2        [NUM_AXES];
  logic signed [NB-1:0]     prod_a    [NUM_AXES];
  logic signed [NB-1:0]     prod_b    [NUM_AXES];
  logic [NB-1:0]            cross_d   [NUM_AXES];
  logic [NB-1:0]            norm_nxt  [NUM_AXES];
  logic [CENT_WIDTH-1:0]    cent_r    [NUM_AXES];
  logic [W-1:0]             box_min_r [NUM_AXES];
  logic [W-1:0]             box_max_r [NUM_AXES];
  logic [NB-1:0]            normal_r  [NUM_AXES];

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // Centroid: offset from scene minimum, scale, clamp to the fraction range
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a]      = {quot[a][W-1], quot[a]} - {scene_min[a][W-1], scene_min[a]};
      diff_pos[a]  = !diff[a][W] && (|diff[a][W-1:0]);
      scale[a]     = PROD_W'(diff[a][W-1:0]) * PROD_W'(inv_extent[a]);
      scale_sat[a] = |scale[a][PROD_W-1:CENT_SHIFT+CENT_WIDTH];
      if (!diff_pos[a]) begin
        cent_nxt[a] = '0;
      end else if (scale_sat[a]) begin
        cent_nxt[a] = CENT_MAX;
      end else begin
        cent_nxt[a] = scale[a][CENT_SHIFT+CENT_WIDTH-1:CENT_SHIFT];
      end
    end
  end

  // Face normal: edge1 x edge2, wrapped at a 64-bit word
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      e1[a] = edge1[a];
      e2[a] = edge2[a];
    end
    prod_a[0] = e1[1] * e2[2];
    prod_b[0] = e1[2] * e2[1];
    prod_a[1] = e1[2] * e2[0];
    prod_b[1] = e1[0] * e2[2];
    prod_a[2] = e1[0] * e2[1];
    prod_b[2] = e1[1] * e2[0];
    for (int a = 0; a < NUM_AXES; a++) begin
      cross_d[a] = prod_a[a] - prod_b[a];
      for (int i = 0; i < NB; i++) begin
        norm_nxt[a][i] = (i < NORMAL_WRAP_BITS) ? cross_d[a][i] : 1'b0;
      end
    end
  end

  // Result valid: fill on accept, drain when the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      cent_r    <= cent_nxt;
      box_min_r <= box_lo;
      box_max_r <= box_hi;
      normal_r  <= norm_nxt;
    end
  end

  assign out_valid = valid_r;
  assign centroid  = cent_r;
  assign box_min   = box_min_r;
  assign box_max   = box_max_r;
  assign normal    = normal_r;

endmodule

// ===== tb/tb_triangle_primitive_setup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for triangle_primitive_setup (centroid, bounding box, face normal).
// Depends on trs_pkg and the block under rtl/core; expected results come from an in-line predictor.

module tb_triangle_primitive_setup import trs_pkg::*;;

  localparam int CW = 24;
  localparam int NW = 2 * CW + 2;
  localparam int DW = (CW > INV_WIDTH) ? CW : INV_WIDTH;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  // indexes past the last register; writes to them must be dropped
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] normal_t;
  typedef logic [CENT_WIDTH-1:0] cent_t;
  typedef enum {ROW_TRI, ROW_CFG} row_kind_t;

  localparam coord_t COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CW - 1){1'b1}}};

  typedef struct {
    coord_t v [NUM_VERTS][NUM_AXES];
  } triangle_t;

  typedef struct {
    cent_t   cent [NUM_AXES];
    coord_t  bmin [NUM_AXES];
    coord_t  bmax [NUM_AXES];
    normal_t nrm  [NUM_AXES];
  } setup_result_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_WIDTH-1:0] idx;
    logic [DW-1:0]            data;
    triangle_t                tri_in;
    bit                       typed;
    setup_result_t            res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [DW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  coord_t in_vert0_x, in_vert0_y, in_vert0_z;
  coord_t in_vert1_x, in_vert1_y, in_vert1_z;
  coord_t in_vert2_x, in_vert2_y, in_vert2_z;
  logic out_valid;
  logic out_ready;
  cent_t out_centroid_x, out_centroid_y, out_centroid_z;
  coord_t out_box_min_x, out_box_min_y, out_box_min_z;
  coord_t out_box_max_x, out_box_max_y, out_box_max_z;
  normal_t out_normal_x, out_normal_y, out_normal_z;

  // register copies used by the predictor
  coord_t scene_min_m [NUM_AXES];
  logic [INV_WIDTH-1:0] inv_extent_m [NUM_AXES];

  setup_result_t pending_q [$];
  stim_row_t directed_q [$];
  setup_result_t no_res;

  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_req = 1'b0;
  int err_count = 0;
  int result_count = 0;

  triangle_primitive_setup #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vert0_x     (in_vert0_x),
    .in_vert0_y     (in_vert0_y),
    .in_vert0_z     (in_vert0_z),
    .in_vert1_x     (in_vert1_x),
    .in_vert1_y     (in_vert1_y),
    .in_vert1_z     (in_vert1_z),
    .in_vert2_x     (in_vert2_x),
    .in_vert2_y     (in_vert2_y),
    .in_vert2_z     (in_vert2_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_centroid_x (out_centroid_x),
    .out_centroid_y (out_centroid_y),
    .out_centroid_z (out_centroid_z),
    .out_box_min_x  (out_box_min_x),
    .out_box_min_y  (out_box_min_y),
    .out_box_min_z  (out_box_min_z),
    .out_box_max_x  (out_box_max_x),
    .out_box_max_y  (out_box_max_y),
    .out_box_max_z  (out_box_max_z),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute centroid, box and normal of one triangle under the current registers
  function automatic setup_result_t predict_setup(input triangle_t t);
    setup_result_t r;
    longint vs [NUM_VERTS];
    longint e1 [NUM_AXES];
    longint e2 [NUM_AXES];
    longint sum, q, diff, scaled;
    longint nx, ny, nz;
    int a, k;
    for (a = 0; a < NUM_AXES; a++) begin
      for (k = 0; k < NUM_VERTS; k++) vs[k] = longint'(t.v[k][a]);
      r.bmin[a] = t.v[0][a];
      r.bmax[a] = t.v[0][a];
      for (k = 1; k < NUM_VERTS; k++) begin
        if (t.v[k][a] < r.bmin[a]) r.bmin[a] = t.v[k][a];
        if (t.v[k][a] > r.bmax[a]) r.bmax[a] = t.v[k][a];
      end
      // floor division: truncation plus a step down for negative remainders
      sum = vs[0] + vs[1] + vs[2];
      q = sum / 3;
      if (sum % 3 != 0 && sum < 0) q = q - 1;
      diff = q - longint'(scene_min_m[a]);
      if (diff <= 0 || inv_extent_m[a] == '0) begin
        r.cent[a] = '0;
      end else begin
        // diff stays below 2^25 and the inverse below 2^32, so the product fits
        scaled = (diff * longint'(inv_extent_m[a])) >>> CENT_SHIFT;
        r.cent[a] = (scaled > longint'(CENT_MAX)) ? CENT_MAX : cent_t'(scaled);
      end
      e1[a] = vs[1] - vs[0];
      e2[a] = vs[2] - vs[0];
    end
    nx = e1[1] * e2[2] - e1[2] * e2[1];
    ny = e1[2] * e2[0] - e1[0] * e2[2];
    nz = e1[0] * e2[1] - e1[1] * e2[0];
    r.nrm[0] = nx[NW-1:0];
    r.nrm[1] = ny[NW-1:0];
    r.nrm[2] = nz[NW-1:0];
    return r;
  endfunction

  function automatic triangle_t mk_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
    triangle_t t;
    t.v[0][0] = coord_t'(x0); t.v[0][1] = coord_t'(y0); t.v[0][2] = coord_t'(z0);
    t.v[1][0] = coord_t'(x1); t.v[1][1] = coord_t'(y1); t.v[1][2] = coord_t'(z1);
    t.v[2][0] = coord_t'(x2); t.v[2][1] = coord_t'(y2); t.v[2][2] = coord_t'(z2);
    return t;
  endfunction

  // Same centroid, box and normal on every axis
  function automatic setup_result_t uniform_res(input cent_t c, input coord_t lo, input coord_t hi,
                                                input normal_t n);
    setup_result_t r;
    int a;
    for (a = 0; a < NUM_AXES; a++) begin
      r.cent[a] = c;
      r.bmin[a] = lo;
      r.bmax[a] = hi;
      r.nrm[a] = n;
    end
    return r;
  endfunction

  task automatic add_tri(input triangle_t t, input bit typed, input setup_result_t r);
    stim_row_t row;
    row.kind = ROW_TRI;
    row.idx = '0;
    row.data = '0;
    row.tri_in = t;
    row.typed = typed;
    row.res = r;
    directed_q.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [DW-1:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    row.typed = 1'b0;
    directed_q.push_back(row);
  endtask

  task automatic add_scene(input int smin, input logic [INV_WIDTH-1:0] inv);
    add_cfg(REG_SCENE_MIN_X, DW'(coord_t'(smin)));
    add_cfg(REG_SCENE_MIN_Y, DW'(coord_t'(smin)));
    add_cfg(REG_SCENE_MIN_Z, DW'(coord_t'(smin)));
    add_cfg(REG_INV_EXTENT_X, DW'(inv));
    add_cfg(REG_INV_EXTENT_Y, DW'(inv));
    add_cfg(REG_INV_EXTENT_Z, DW'(inv));
  endtask

  // Directed rows; typed results only where they are obvious
  task automatic build_directed();
    // reset registers: zero inverse extent gives zero centroids
    add_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, uniform_res('0, '0, '0, '0));
    add_tri(mk_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b1,
            uniform_res('0, COORD_MAX, COORD_MAX, '0));
    add_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1,
            uniform_res('0, COORD_MIN, COORD_MIN, '0));
    add_tri(mk_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0), 1'b1,
            uniform_res('0, COORD_MIN, COORD_MAX, '0));
    // largest edge products on the normal
    add_tri(mk_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX), 1'b0, no_res);
    add_tri(mk_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN), 1'b0, no_res);
    add_tri(mk_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1'b0, no_res);
    // widest scene: far corner saturates, scene minimum itself maps to zero
    add_scene(CMIN, '1);
    add_tri(mk_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b1,
            uniform_res(CENT_MAX, COORD_MAX, COORD_MAX, '0));
    add_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1,
            uniform_res('0, COORD_MIN, COORD_MIN, '0));
    add_tri(mk_tri(CMIN + 3, CMIN, CMIN + 1, CMIN, CMIN + 2, CMIN, CMIN, CMIN, CMIN + 5),
            1'b0, no_res);
    // centroid at or below the scene minimum clamps to zero
    add_scene(CMAX, 1);
    add_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1,
            uniform_res('0, COORD_MIN, COORD_MIN, '0));
    add_tri(mk_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b1,
            uniform_res('0, COORD_MAX, COORD_MAX, '0));
    // unit scale exposes the rounding of negative vertex sums
    add_scene(-4, INV_WIDTH'(1 << CENT_SHIFT));
    add_tri(mk_tri(-1, -2, -3, 0, 0, 0, 0, 0, 0), 1'b0, no_res);
    add_tri(mk_tri(-1, -1, -1, -1, -1, -1, 0, 0, -1), 1'b0, no_res);
    add_tri(mk_tri(-2, -5, -7, 1, -3, 2, -6, 0, -9), 1'b0, no_res);
    // writes past the register file leave the settings alone
    add_cfg(REG_SPARE_A, '1);
    add_cfg(REG_SPARE_B, DW'(32'h00FF_F00F));
    add_tri(mk_tri(-1, -2, -3, 0, 0, 0, 0, 0, 0), 1'b0, no_res);
    // degenerate x axis
    add_cfg(REG_INV_EXTENT_X, '0);
    add_tri(mk_tri(400, 800, 1200, 40, 80, 120, 4, 8, 12), 1'b0, no_res);
    add_tri(mk_tri(CMAX, -7, 3, CMIN, 5, -2, 12345, -999, 77), 1'b0, no_res);
  endtask

  function automatic triangle_t random_triangle();
    triangle_t t;
    int mode, k, a, src;
    mode = $urandom_range(0, 9);
    for (k = 0; k < NUM_VERTS; k++) begin
      for (a = 0; a < NUM_AXES; a++) begin
        case (mode)
          4, 5, 6: t.v[k][a] = coord_t'(longint'(scene_min_m[a]) +
                                        longint'($urandom_range(0, 1 << 20)));
          7: begin
            case ($urandom_range(0, 5))
              0: t.v[k][a] = COORD_MIN;
              1: t.v[k][a] = COORD_MAX;
              2: t.v[k][a] = '0;
              3: t.v[k][a] = '1;
              4: t.v[k][a] = coord_t'(1);
              default: t.v[k][a] = coord_t'($urandom());
            endcase
          end
          9: t.v[k][a] = coord_t'(int'($urandom_range(0, 8191)) - 4096);
          default: t.v[k][a] = coord_t'($urandom());
        endcase
      end
    end
    // collapse a vertex onto another for a zero-area triangle
    if (mode == 8) begin
      src = $urandom_range(0, 1);
      for (a = 0; a < NUM_AXES; a++) t.v[2][a] = t.v[src][a];
    end
    return t;
  endfunction

  function automatic coord_t random_scene_min();
    coord_t m;
    case ($urandom_range(0, 7))
      0: m = COORD_MIN;
      1: m = COORD_MAX;
      2, 3: m = coord_t'($urandom());
      default: m = coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
    return m;
  endfunction

  function automatic logic [INV_WIDTH-1:0] random_inv();
    logic [INV_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3: v = $urandom();
      default: v = $urandom_range(1 << 12, 1 << 20);
    endcase
    return v;
  endfunction

  // One register write; mirror it into the predictor's copy
  task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SCENE_MIN_X: scene_min_m[0] = data[CW-1:0];
      REG_SCENE_MIN_Y: scene_min_m[1] = data[CW-1:0];
      REG_SCENE_MIN_Z: scene_min_m[2] = data[CW-1:0];
      REG_INV_EXTENT_X: inv_extent_m[0] = data[INV_WIDTH-1:0];
      REG_INV_EXTENT_Y: inv_extent_m[1] = data[INV_WIDTH-1:0];
      REG_INV_EXTENT_Z: inv_extent_m[2] = data[INV_WIDTH-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write a scene minimum with junk in the bits above the coordinate
  task automatic write_scene_min(input logic [CFG_IDX_WIDTH-1:0] idx, input coord_t m);
    logic [DW-1:0] d;
    d = $urandom();
    d[CW-1:0] = m;
    cfg_write(idx, d);
  endtask

  // Offer one triangle and hold it until the block takes it
  task automatic send_triangle(input triangle_t t, input bit typed, input setup_result_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vert0_x <= t.v[0][0]; in_vert0_y <= t.v[0][1]; in_vert0_z <= t.v[0][2];
    in_vert1_x <= t.v[1][0]; in_vert1_y <= t.v[1][1]; in_vert1_z <= t.v[1][2];
    in_vert2_x <= t.v[2][0]; in_vert2_y <= t.v[2][1]; in_vert2_z <= t.v[2][2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(typed ? r : predict_setup(t));
  endtask

  // Drop valid and wait until every pending result is out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field, input int axis,
                               input logic signed [63:0] want, input logic signed [63:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("result %0d: %s[%0d] expected %0d got %0d", result_count, field, axis, want, got);
  endtask

  task automatic compare_result(input setup_result_t want, input setup_result_t got);
    int a;
    for (a = 0; a < NUM_AXES; a++) begin
      if (want.cent[a] !== got.cent[a]) flag_mismatch("centroid", a, want.cent[a], got.cent[a]);
      if (want.bmin[a] !== got.bmin[a]) flag_mismatch("box_min", a, want.bmin[a], got.bmin[a]);
      if (want.bmax[a] !== got.bmax[a]) flag_mismatch("box_max", a, want.bmax[a], got.bmax[a]);
      if (want.nrm[a] !== got.nrm[a]) flag_mismatch("normal", a, want.nrm[a], got.nrm[a]);
    end
  endtask

  // Score every result transaction against the oldest pending prediction
  initial begin : result_monitor
    setup_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.cent[0] = out_centroid_x; got.cent[1] = out_centroid_y; got.cent[2] = out_centroid_z;
        got.bmin[0] = out_box_min_x; got.bmin[1] = out_box_min_y; got.bmin[2] = out_box_min_z;
        got.bmax[0] = out_box_max_x; got.bmax[1] = out_box_max_y; got.bmax[2] = out_box_max_z;
        got.nrm[0] = out_normal_x; got.nrm[1] = out_normal_y; got.nrm[2] = out_normal_z;
        if (pending_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("result %0d arrived with nothing pending", result_count);
        end else begin
          compare_result(pending_q.pop_front(), got);
        end
        result_count++;
      end
    end
  end

  // Result side back-pressure: short random stalls, one long hold-off on request
  initial begin : result_sink
    int c;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    int p, a;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SCENE_MIN_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_vert0_x <= '0; in_vert0_y <= '0; in_vert0_z <= '0;
    in_vert1_x <= '0; in_vert1_y <= '0; in_vert1_z <= '0;
    in_vert2_x <= '0; in_vert2_y <= '0; in_vert2_z <= '0;
    for (a = 0; a < NUM_AXES; a++) begin
      scene_min_m[a] = '0;
      inv_extent_m[a] = '0;
    end
    build_directed();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.kind == ROW_CFG) begin
        drain_pipeline();
        cfg_write(row.idx, row.data);
      end else begin
        send_triangle(row.tri_in, row.typed, row.res);
      end
    end

    // random phases, each under fresh register settings
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      if (p == 0) begin
        write_scene_min(REG_SCENE_MIN_X, COORD_MIN);
        write_scene_min(REG_SCENE_MIN_Y, COORD_MIN);
        write_scene_min(REG_SCENE_MIN_Z, COORD_MIN);
        cfg_write(REG_INV_EXTENT_X, '1);
        cfg_write(REG_INV_EXTENT_Y, '1);
        cfg_write(REG_INV_EXTENT_Z, '1);
      end else if (p == 1) begin
        write_scene_min(REG_SCENE_MIN_X, '0);
        write_scene_min(REG_SCENE_MIN_Y, '0);
        write_scene_min(REG_SCENE_MIN_Z, '0);
        cfg_write(REG_INV_EXTENT_X, DW'(1 << 16));
        cfg_write(REG_INV_EXTENT_Y, DW'(1 << 16));
        cfg_write(REG_INV_EXTENT_Z, DW'(1 << 16));
      end else begin
        write_scene_min(REG_SCENE_MIN_X, random_scene_min());
        write_scene_min(REG_SCENE_MIN_Y, random_scene_min());
        write_scene_min(REG_SCENE_MIN_Z, random_scene_min());
        cfg_write(REG_INV_EXTENT_X, DW'(random_inv()));
        cfg_write(REG_INV_EXTENT_Y, DW'(random_inv()));
        cfg_write(REG_INV_EXTENT_Z, DW'(random_inv()));
      end
      if ($urandom_range(0, 1) == 1)
        cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DW'($urandom()));
      // no idling in phase 3 and in the closing one
      gaps_on = (p != 3 && p != NUM_PHASES - 1);
      stalls_on = gaps_on;
      if (p == PRESSURE_PHASE) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_triangle(random_triangle(), 1'b0, no_res);
    end

    drain_pipeline();
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
